// ===== design/mrc_pkg.sv =====
// Package for the Modbus RTU reply checker: codes, widths, queue entry types
// and the CRC-16 byte update. Depends on nothing; every other design file imports it.
`default_nettype none

package mrc_pkg;

   // Command codes on the request channel
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_BYTE   = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Result status codes
   localparam logic [1:0] STATUS_SUCCESS = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
   localparam logic [1:0] STATUS_BAD     = 2'd2;
   localparam logic [1:0] STATUS_CRC     = 2'd3;

   // Register indexes on the CSR port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLAVE_ADDRESS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 1'b1;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

   // Frame geometry
   localparam int LEN_W = 9;
   localparam logic [LEN_W-1:0] MAX_FRAME = 9'd256;
   localparam logic [LEN_W-1:0] MIN_REPLY = 9'd5;

   // Protocol constants
   localparam logic [15:0] CRC_POLY        = 16'hA001;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [7:0]  FN_READ_HOLDING = 8'h03;

   // Decoupling queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Classified operation handed from front to back
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [7:0]       data;     // received byte, or function code on start
      logic [LEN_W-1:0] length;   // saturated expected length on start
   } queue_entry_type;

   typedef struct packed {
      logic            push;
      queue_entry_type entry;
   } queue_wr_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_rd_type;

   // One byte through reflected CRC-16
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/mrc_if.sv =====
// Channel interfaces for the request and result sides of the reply checker.
// Depends on mrc_pkg for field widths.
`default_nettype none

interface mrc_req_if;
   import mrc_pkg::*;
   logic             valid;
   logic             ready;
   logic [1:0]       cmd;
   logic [7:0]       rx_byte;
   logic [7:0]       expected_function;
   logic [LEN_W-1:0] expected_length;

   modport source (output valid, output cmd, output rx_byte,
                   output expected_function, output expected_length, input ready);
   modport sink   (input valid, input cmd, input rx_byte,
                   input expected_function, input expected_length, output ready);
endinterface

interface mrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       is_exception;
   logic [7:0] exception_code;

   modport source (output valid, output status, output is_exception,
                   output exception_code, input ready);
   modport sink   (input valid, input status, input is_exception,
                   input exception_code, output ready);
endinterface

`default_nettype wire

// ===== design/mrc_front.sv =====
// Front end: accepts request items, drops unused commands, saturates the
// expected length and pushes classified operations into the queue. Uses mrc_pkg.
`default_nettype none

module mrc_front (
   mrc_req_if.sink                 req_bus,
   input  wire logic               queue_full,
   output mrc_pkg::queue_wr_type   queue_wr
);
   import mrc_pkg::*;

   logic [LEN_W-1:0] length_sat;

   // Accept whenever the queue has room
   assign req_bus.ready = !queue_full;

   assign length_sat = (req_bus.expected_length > MAX_FRAME) ? MAX_FRAME
                                                             : req_bus.expected_length;

   // Classify the item
   always_comb begin
      queue_wr.push         = 1'b0;
      queue_wr.entry.op     = OP_TICK;
      queue_wr.entry.data   = req_bus.rx_byte;
      queue_wr.entry.length = length_sat;
      case (req_bus.cmd)
         CMD_START: begin
            queue_wr.push       = req_bus.valid && !queue_full;
            queue_wr.entry.op   = OP_START;
            queue_wr.entry.data = req_bus.expected_function;
         end
         CMD_BYTE: begin
            queue_wr.push     = req_bus.valid && !queue_full;
            queue_wr.entry.op = OP_BYTE;
         end
         CMD_TICK: begin
            queue_wr.push     = req_bus.valid && !queue_full;
            queue_wr.entry.op = OP_TICK;
         end
         default: begin
            // unused command: taken and dropped
            queue_wr.push = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/mrc_queue.sv =====
// Short queue between front and back of the reply checker, show-ahead read.
// Uses mrc_pkg for the entry type and depth.
`default_nettype none

module mrc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  mrc_pkg::queue_wr_type  wr,
   output logic                   full,
   output mrc_pkg::queue_rd_type  rd,
   input  wire logic              pop
);
   import mrc_pkg::*;

   queue_entry_type        mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign rd.valid = (count_ff != '0);
   assign rd.entry = mem[rd_ptr_ff];

   assign do_push = wr.push && !full;
   assign do_pop  = pop && rd.valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wr.entry;
      end
   end

endmodule

`default_nettype wire

// ===== design/mrc_back.sv =====
// Back end: frame state (count, CRC, header capture, timeout) and result register;
// one operation per cycle unless the result stalls. Uses mrc_pkg and mrc_rsp_if.
`default_nettype none

module mrc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  mrc_pkg::queue_rd_type  rd,
   output logic                   pop,
   input  wire logic [7:0]        slave_address,
   input  wire logic [15:0]       timeout_ticks,
   mrc_rsp_if.source              rsp_bus
);
   import mrc_pkg::*;

   // Frame state
   logic             armed_ff, armed_in;
   logic [LEN_W-1:0] bytes_seen_ff, bytes_seen_in;
   logic [LEN_W-1:0] frame_length_ff, frame_length_in;
   logic [7:0]       sent_function_ff, sent_function_in;
   logic [15:0]      crc_ff, crc_in;
   logic [15:0]      last_two_ff, last_two_in;
   logic [23:0]      header_ff, header_in;
   logic [15:0]      tick_ff, tick_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       status_ff, status_in;
   logic             is_exc_ff, is_exc_in;
   logic [7:0]       exc_code_ff, exc_code_in;

   // Byte path
   logic [7:0]       b;
   logic [15:0]      crc_next;
   logic [15:0]      last_two_next;
   logic [23:0]      header_next;
   logic [LEN_W-1:0] length_next;
   logic [LEN_W-1:0] seen_next;
   logic [LEN_W-1:0] target;
   logic             frame_done;
   logic [7:0]       a0, f1, c2;
   logic [15:0]      rx_crc;
   logic [1:0]       byte_status;
   logic             byte_exc;
   logic [7:0]       byte_code;

   // Tick path
   logic [16:0]      tick_next;
   logic             tick_expired;

   logic             back_ready;
   logic             emit;

   assign back_ready = !rsp_valid_ff || rsp_bus.ready;
   assign pop        = back_ready && rd.valid;
   assign b          = rd.entry.data;

   // Received byte: CRC lags two bytes so the trailing CRC stays out of it
   always_comb begin
      crc_next      = (bytes_seen_ff >= LEN_W'(2)) ? crc_feed(crc_ff, last_two_ff[15:8])
                                                   : crc_ff;
      last_two_next = {last_two_ff[7:0], b};
      header_next   = header_ff;
      case (bytes_seen_ff)
         LEN_W'(0): header_next[7:0]   = b;
         LEN_W'(1): header_next[15:8]  = b;
         LEN_W'(2): header_next[23:16] = b;
         default:   header_next        = header_ff;
      endcase
      // exception reply is five bytes long
      length_next = (bytes_seen_ff == LEN_W'(1) && b[7]) ? MIN_REPLY : frame_length_ff;
      seen_next   = bytes_seen_ff + 1'b1;
      target      = (length_next < MIN_REPLY) ? MIN_REPLY : length_next;
      frame_done  = (seen_next >= target);
   end

   // Final checks, first failure wins
   assign a0     = header_next[7:0];
   assign f1     = header_next[15:8];
   assign c2     = header_next[23:16];
   assign rx_crc = {last_two_next[7:0], last_two_next[15:8]};

   always_comb begin
      byte_status = STATUS_SUCCESS;
      byte_exc    = 1'b0;
      byte_code   = 8'h00;
      if (length_next < MIN_REPLY) begin
         byte_status = STATUS_BAD;
      end else if (a0 != slave_address) begin
         byte_status = STATUS_BAD;
      end else if (f1[7]) begin
         byte_status = STATUS_BAD;
         byte_exc    = 1'b1;
         byte_code   = c2;
      end else if (f1 != sent_function_ff) begin
         byte_status = STATUS_BAD;
      end else if (sent_function_ff == FN_READ_HOLDING
                   && c2 != 8'(target - MIN_REPLY)) begin
         byte_status = STATUS_BAD;
      end else if (rx_crc != crc_next) begin
         byte_status = STATUS_CRC;
      end
   end

   // Tick count against the timeout
   assign tick_next    = {1'b0, tick_ff} + 17'd1;
   assign tick_expired = (tick_next > {1'b0, timeout_ticks});

   // Operation dispatch
   always_comb begin
      armed_in         = armed_ff;
      bytes_seen_in    = bytes_seen_ff;
      frame_length_in  = frame_length_ff;
      sent_function_in = sent_function_ff;
      crc_in           = crc_ff;
      last_two_in      = last_two_ff;
      header_in        = header_ff;
      tick_in          = tick_ff;
      emit             = 1'b0;
      status_in        = status_ff;
      is_exc_in        = is_exc_ff;
      exc_code_in      = exc_code_ff;
      if (pop) begin
         case (rd.entry.op)
            OP_START: begin
               armed_in         = 1'b1;
               sent_function_in = rd.entry.data;
               frame_length_in  = rd.entry.length;
               bytes_seen_in    = '0;
               crc_in           = CRC_INIT;
               last_two_in      = '0;
               header_in        = '0;
               tick_in          = '0;
            end
            OP_BYTE: begin
               if (armed_ff) begin
                  crc_in          = crc_next;
                  last_two_in     = last_two_next;
                  header_in       = header_next;
                  frame_length_in = length_next;
                  bytes_seen_in   = seen_next;
                  if (frame_done) begin
                     emit        = 1'b1;
                     armed_in    = 1'b0;
                     status_in   = byte_status;
                     is_exc_in   = byte_exc;
                     exc_code_in = byte_code;
                  end
               end
            end
            OP_TICK: begin
               if (armed_ff) begin
                  if (tick_expired) begin
                     emit        = 1'b1;
                     armed_in    = 1'b0;
                     status_in   = STATUS_TIMEOUT;
                     is_exc_in   = 1'b0;
                     exc_code_in = 8'h00;
                  end else begin
                     tick_in = tick_next[15:0];
                  end
               end
            end
            default: begin
               armed_in = armed_ff;
            end
         endcase
      end
   end

   // Output register valid
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff         <= 1'b0;
         bytes_seen_ff    <= '0;
         frame_length_ff  <= '0;
         sent_function_ff <= '0;
         crc_ff           <= CRC_INIT;
         last_two_ff      <= '0;
         header_ff        <= '0;
         tick_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         armed_ff         <= armed_in;
         bytes_seen_ff    <= bytes_seen_in;
         frame_length_ff  <= frame_length_in;
         sent_function_ff <= sent_function_in;
         crc_ff           <= crc_in;
         last_two_ff      <= last_two_in;
         header_ff        <= header_in;
         tick_ff          <= tick_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      is_exc_ff   <= is_exc_in;
      exc_code_ff <= exc_code_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = status_ff;
   assign rsp_bus.is_exception   = is_exc_ff;
   assign rsp_bus.exception_code = exc_code_ff;

endmodule

`default_nettype wire

// ===== design/modbus_rtu_response_checker_top.sv =====
// Top level of the Modbus RTU reply checker: CSR registers, front, queue, back.
// Depends on mrc_pkg, mrc_if, mrc_front, mrc_queue and mrc_back.
//
// Checks one Modbus RTU reply as its bytes arrive. A start item (cmd 0) arms the
// block with the function code sent and the normal reply length (above 256 is
// taken as 256); byte items (cmd 1) are counted and run through CRC-16, tick
// items (cmd 2) count toward timeout_ticks, and one result comes out when the
// frame ends or times out. The block takes one item per clock cycle while the
// queue has room: each item is one step of the back end, whose byte-wide CRC
// update, header capture and final checks are combinational; the result is
// registered as the back end takes the frame's last item. A four-entry queue
// sits between the accepting front end and the back end, and the result sits in
// an output register, so input keeps flowing for four items while a result waits.
// CSR index 0 is slave_address (reset 0), index 1 is timeout_ticks (reset 1000);
// write them only while no frame is in flight.
`default_nettype none

module modbus_rtu_response_checker_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   mrc_req_if.sink                              req_bus,
   mrc_rsp_if.source                            rsp_bus,
   input  wire logic                            csr_we,
   input  wire logic [mrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mrc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mrc_pkg::*;

   logic [7:0]    slave_address_ff, slave_address_in;
   logic [15:0]   timeout_ticks_ff, timeout_ticks_in;
   queue_wr_type  queue_wr;
   queue_rd_type  queue_rd;
   logic          queue_full;
   logic          queue_pop;

   // Configuration registers
   always_comb begin
      slave_address_in = slave_address_ff;
      timeout_ticks_in = timeout_ticks_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SLAVE_ADDRESS: slave_address_in = csr_wdata[7:0];
            CSR_TIMEOUT_TICKS: timeout_ticks_in = csr_wdata[15:0];
            default:           slave_address_in = slave_address_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= 8'h00;
         timeout_ticks_ff <= TIMEOUT_TICKS_RESET;
      end else begin
         slave_address_ff <= slave_address_in;
         timeout_ticks_ff <= timeout_ticks_in;
      end
   end

   mrc_front u_front (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .queue_wr   (queue_wr)
   );

   mrc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (queue_wr),
      .full  (queue_full),
      .rd    (queue_rd),
      .pop   (queue_pop)
   );

   mrc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .rd            (queue_rd),
      .pop           (queue_pop),
      .slave_address (slave_address_ff),
      .timeout_ticks (timeout_ticks_ff),
      .rsp_bus       (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== design/mrc_checker.sv =====
// Port-level checks on the reply checker's result channel, bound to the top.
// Depends on mrc_pkg and modbus_rtu_response_checker_top.
`default_nettype none

module mrc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_is_exception,
   input wire logic [7:0] rsp_exception_code
);
   import mrc_pkg::*;

   // No result is offered right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result stays offered
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // Exception replies are always reported as bad responses
   a_exc_is_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_exception |-> rsp_status == STATUS_BAD)
      else $error("exception reply with wrong status");

   // An exception code only comes with an exception reply
   a_code_needs_exc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exception_code != 8'h00 |-> rsp_is_exception)
      else $error("exception code without exception flag");

endmodule

bind modbus_rtu_response_checker_top mrc_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_status         (rsp_bus.status),
   .rsp_is_exception   (rsp_bus.is_exception),
   .rsp_exception_code (rsp_bus.exception_code)
);

`default_nettype wire

// ===== dv/mrc_tb_pkg.sv =====
`timescale 1ns / 1ps
// Testbench helpers for the Modbus RTU reply checker: the reflected CRC-16 byte
// update, used both to build replies and to predict verdicts. Depends on mrc_pkg.

package mrc_tb_pkg;

   // Bit-serial form of the reflected CRC-16 update, one byte, LSB first
   function automatic logic [15:0] mb_crc16(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ d[i];
         r  = r >> 1;
         if (fb) begin
            r = r ^ mrc_pkg::CRC_POLY;
         end
      end
      return r;
   endfunction

endpackage

// ===== dv/mrc_verdict_monitor.sv =====
`timescale 1ns / 1ps
// Verdict monitor for the Modbus RTU reply checker: tracks CSR writes and accepted
// items, predicts each verdict and compares it with the result channel.
// Depends on mrc_pkg, mrc_tb_pkg and the channel interfaces in mrc_if.

module mrc_verdict_monitor (
   input  wire logic                            clock,
   input  wire logic                            reset,
   mrc_req_if                                   req_tap,
   mrc_rsp_if                                   rsp_tap,
   input  wire logic                            csr_we,
   input  wire logic [mrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mrc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                   failures,
   output int                                   pending
);
   import mrc_pkg::*;

   typedef struct packed {
      logic [1:0] status;
      logic       is_exc;
      logic [7:0] code;
   } verdict_type;

   verdict_type verdicts_due [$];
   verdict_type seen;

   // Register copies
   logic [7:0]       cfg_addr;
   logic [15:0]      cfg_timeout;

   // Frame tracking
   logic             frame_armed;
   logic [LEN_W-1:0] byte_count;
   logic [LEN_W-1:0] reply_len;
   logic [7:0]       fn_sent;
   logic [15:0]      crc_acc;
   logic [15:0]      tail_bytes;
   logic [23:0]      head_bytes;
   logic [15:0]      ticks_elapsed;

   task automatic post_verdict(input logic [1:0] st, input logic exc, input logic [7:0] code);
      verdict_type v;
      v.status = st;
      v.is_exc = exc;
      v.code   = code;
      verdicts_due.push_back(v);
      frame_armed = 1'b0;
   endtask

   task automatic clear_frame();
      byte_count    = '0;
      crc_acc       = CRC_INIT;
      tail_bytes    = '0;
      head_bytes    = '0;
      ticks_elapsed = '0;
   endtask

   // Advance the frame state by one accepted item
   task automatic take_item(input logic [1:0] c, input logic [7:0] b, input logic [7:0] fn,
                            input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] idx;
      logic [LEN_W-1:0] tgt;
      logic [16:0]      next_ticks;
      logic [15:0]      got_crc;
      logic [7:0]       a0, f1, c2;
      if (c == CMD_START) begin
         reply_len   = (len > MAX_FRAME) ? MAX_FRAME : len;
         fn_sent     = fn;
         clear_frame();
         frame_armed = 1'b1;
         return;
      end
      if (!frame_armed || c == CMD_UNUSED) begin
         return;
      end
      if (c == CMD_TICK) begin
         next_ticks = {1'b0, ticks_elapsed} + 17'd1;
         if (next_ticks > {1'b0, cfg_timeout}) begin
            post_verdict(STATUS_TIMEOUT, 1'b0, 8'h00);
         end else begin
            ticks_elapsed = next_ticks[15:0];
         end
         return;
      end
      // received byte: the last two bytes are the CRC, so feed with a two-byte lag
      idx = byte_count;
      if (idx >= 2) begin
         crc_acc = mrc_tb_pkg::mb_crc16(crc_acc, tail_bytes[15:8]);
      end
      tail_bytes = {tail_bytes[7:0], b};
      if (idx < 3) begin
         head_bytes[8*idx +: 8] = b;
      end
      if (idx == 1 && b[7]) begin
         reply_len = MIN_REPLY;
      end
      byte_count = idx + 1'b1;
      tgt = (reply_len < MIN_REPLY) ? MIN_REPLY : reply_len;
      if (byte_count < tgt) begin
         return;
      end
      a0 = head_bytes[7:0];
      f1 = head_bytes[15:8];
      c2 = head_bytes[23:16];
      got_crc = {tail_bytes[7:0], tail_bytes[15:8]};
      if (reply_len < MIN_REPLY) begin
         post_verdict(STATUS_BAD, 1'b0, 8'h00);
      end else if (a0 != cfg_addr) begin
         post_verdict(STATUS_BAD, 1'b0, 8'h00);
      end else if (f1[7]) begin
         post_verdict(STATUS_BAD, 1'b1, c2);
      end else if (f1 != fn_sent) begin
         post_verdict(STATUS_BAD, 1'b0, 8'h00);
      end else if (fn_sent == FN_READ_HOLDING && c2 != 8'(tgt - MIN_REPLY)) begin
         post_verdict(STATUS_BAD, 1'b0, 8'h00);
      end else if (got_crc != crc_acc) begin
         post_verdict(STATUS_CRC, 1'b0, 8'h00);
      end else begin
         post_verdict(STATUS_SUCCESS, 1'b0, 8'h00);
      end
   endtask

   // Compare one result against the oldest predicted verdict
   task automatic match_result(input verdict_type got);
      verdict_type want;
      if (verdicts_due.size() == 0) begin
         failures++;
         if (failures <= 10) begin
            $display("%0t: result with nothing due: status %0d exc %0b code %02h",
                     $realtime, got.status, got.is_exc, got.code);
         end
         return;
      end
      want = verdicts_due.pop_front();
      if (got.status !== want.status || got.is_exc !== want.is_exc ||
          got.code !== want.code) begin
         failures++;
         if (failures <= 10) begin
            $display({"%0t: verdict mismatch: expected status %0d exc %0b code %02h,",
                      " got status %0d exc %0b code %02h"},
                     $realtime, want.status, want.is_exc, want.code,
                     got.status, got.is_exc, got.code);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_addr    = 8'h00;
         cfg_timeout = TIMEOUT_TICKS_RESET;
         frame_armed = 1'b0;
         reply_len   = '0;
         fn_sent     = 8'h00;
         clear_frame();
         verdicts_due.delete();
         failures    = 0;
      end else begin
         if (csr_we === 1'b1) begin
            if (csr_index == CSR_SLAVE_ADDRESS) begin
               cfg_addr = csr_wdata[7:0];
            end else if (csr_index == CSR_TIMEOUT_TICKS) begin
               cfg_timeout = csr_wdata[15:0];
            end
         end
         if (req_tap.valid === 1'b1 && req_tap.ready === 1'b1) begin
            take_item(req_tap.cmd, req_tap.rx_byte, req_tap.expected_function,
                      req_tap.expected_length);
         end
         if (rsp_tap.valid === 1'b1 && rsp_tap.ready === 1'b1) begin
            seen.status = rsp_tap.status;
            seen.is_exc = rsp_tap.is_exception;
            seen.code   = rsp_tap.exception_code;
            match_result(seen);
         end
      end
      pending = verdicts_due.size();
   end

endmodule

// ===== dv/modbus_rtu_response_checker_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the Modbus RTU reply checker: clock, reset, CSR writes and
// reply stimulus; verdicts come from mrc_verdict_monitor. Depends on mrc_pkg,
// mrc_tb_pkg, mrc_if, mrc_verdict_monitor and modbus_rtu_response_checker_top.

module modbus_rtu_response_checker_top_tb;
   import mrc_pkg::*;
   import mrc_tb_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int LIMIT       = 400000;
   localparam int DRAIN       = 8;
   localparam int PHASE_ITEMS = 75;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int failures;
   int pending;
   int cycles     = 0;
   int sent_items = 0;
   int gap_pct    = 0;
   int stall_pct  = 0;
   int stall_left = 0;
   int tick_pct   = 0;

   logic [7:0]  cur_addr;
   logic [15:0] cur_timeout;

   mrc_req_if req_bus ();
   mrc_rsp_if rsp_bus ();

   modbus_rtu_response_checker_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mrc_verdict_monitor verdict_mon (
      .clock     (clock),
      .reset     (reset),
      .req_tap   (req_bus),
      .rsp_tap   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side: ready dropped in random stall bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left    = $urandom_range(1, 6) - 1;
         rsp_bus.ready = 1'b0;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   // Drive one item at the falling edge and hold it until accepted
   task automatic put_item(input logic [1:0] c, input logic [7:0] b, input logic [7:0] fn,
                           input logic [LEN_W-1:0] len);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_bus.valid             = 1'b1;
      req_bus.cmd               = c;
      req_bus.rx_byte           = b;
      req_bus.expected_function = fn;
      req_bus.expected_length   = len;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
      sent_items++;
   endtask

   // Append the CRC (low byte first) and send the reply bytes, stopping at cut
   task automatic send_reply(input logic [7:0] body [$], input logic [15:0] crc_flip,
                             input int cut);
      logic [15:0] crc;
      crc = CRC_INIT;
      foreach (body[k]) begin
         crc = mb_crc16(crc, body[k]);
      end
      crc = crc ^ crc_flip;
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
      foreach (body[k]) begin
         if (k == cut) begin
            break;
         end
         if (tick_pct != 0 && $urandom_range(0, 99) < tick_pct) begin
            put_item(CMD_TICK, 8'($urandom()), 8'($urandom()), 9'($urandom()));
         end
         if (tick_pct != 0 && $urandom_range(0, 49) == 0) begin
            put_item(CMD_UNUSED, 8'($urandom()), 8'($urandom()), 9'($urandom()));
         end
         put_item(CMD_BYTE, body[k], 8'($urandom()), 9'($urandom()));
      end
   endtask

   // One start item plus a mostly well-formed reply; want_len forces a read reply size
   task automatic send_frame(input int want_len);
      logic [7:0]       fn;
      logic [7:0]       cnt;
      logic [LEN_W-1:0] len_field;
      logic [7:0]       body [$];
      logic [15:0]      crc_flip;
      int               n;
      int               cut;
      int               pick;
      bit               excp;
      bit               stall;
      fn   = $urandom_range(0, 1) ? FN_READ_HOLDING : 8'($urandom());
      excp = fn[7] || ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (want_len != 0) begin
         fn   = FN_READ_HOLDING;
         excp = 1'b0;
         n    = want_len;
      end else if (excp) begin
         n = 5;
      end else if (pick < 85) begin
         n = $urandom_range(5, 16);
      end else if (pick < 97) begin
         n = $urandom_range(17, 64);
      end else begin
         n = $urandom_range(65, 256);
      end
      len_field = 9'(n);
      if (excp) begin
         // exception replies are always five bytes, whatever was announced
         len_field = 9'($urandom());
      end else if (n == 256 && $urandom_range(0, 1) == 1) begin
         len_field = 9'($urandom_range(257, 511));
      end else if (want_len == 0 && $urandom_range(0, 29) == 0) begin
         // announced length below the minimum reply
         n         = 5;
         len_field = 9'($urandom_range(0, 4));
      end

      body.push_back(($urandom_range(0, 9) == 0) ? cur_addr ^ 8'($urandom_range(1, 255))
                                                 : cur_addr);
      if (excp) begin
         body.push_back(fn | 8'h80);
         body.push_back(8'($urandom()));
      end else begin
         body.push_back(($urandom_range(0, 9) == 0) ? fn ^ 8'($urandom_range(1, 127)) : fn);
         cnt = (fn == FN_READ_HOLDING) ? 8'(n - 5) : 8'($urandom());
         if ($urandom_range(0, 9) == 0) begin
            cnt = cnt ^ 8'($urandom_range(1, 255));
         end
         body.push_back(cnt);
         while (body.size() < n - 2) begin
            body.push_back(8'($urandom()));
         end
      end
      crc_flip = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;

      // abandoned frames are cut short and dropped by the next start
      cut   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n - 1) : -1;
      stall = (want_len == 0 && cur_timeout <= 16'd64 && $urandom_range(0, 7) == 0);
      if (stall) begin
         cut = $urandom_range(0, n - 1);
      end

      put_item(CMD_START, 8'($urandom()), fn, len_field);
      send_reply(body, crc_flip, cut);
      if (stall) begin
         repeat (int'(cur_timeout) + 1) begin
            put_item(CMD_TICK, 8'($urandom()), 8'($urandom()), 9'($urandom()));
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] val);
      csr_index = idx;
      csr_wdata = val;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_SLAVE_ADDRESS) begin
         cur_addr = val[7:0];
      end else begin
         cur_timeout = val;
      end
   endtask

   // Stop sending, let every verdict arrive and the pipeline empty
   task automatic settle();
      req_bus.valid = 1'b0;
      wait (pending == 0);
      repeat (DRAIN) @(negedge clock);
   endtask

   initial begin
      logic [7:0]  ph_addr [4];
      logic [15:0] ph_timeout [4];
      int          phase_end;

      req_bus.valid             = 1'b0;
      req_bus.cmd               = CMD_START;
      req_bus.rx_byte           = 8'h00;
      req_bus.expected_function = 8'h00;
      req_bus.expected_length   = '0;
      rsp_bus.ready             = 1'b1;
      csr_we                    = 1'b0;
      csr_index                 = CSR_SLAVE_ADDRESS;
      csr_wdata                 = '0;
      cur_addr                  = 8'h00;
      cur_timeout               = TIMEOUT_TICKS_RESET;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, registers at reset values: stray items while idle, then a clean read
      gap_pct   = 20;
      stall_pct = 20;
      put_item(CMD_BYTE, 8'hFF, 8'h00, 9'h1FF);
      put_item(CMD_TICK, 8'h00, 8'hFF, 9'h000);
      put_item(CMD_UNUSED, 8'hAA, 8'h55, 9'h155);
      put_item(CMD_START, 8'h5A, FN_READ_HOLDING, 9'd7);
      send_reply('{8'h00, FN_READ_HOLDING, 8'h02, 8'h12, 8'h34}, 16'h0000, -1);
      settle();

      // Directed, address 0xFF and zero timeout
      write_reg(CSR_SLAVE_ADDRESS, 16'h00FF);
      write_reg(CSR_TIMEOUT_TICKS, 16'h0000);
      // oversize length saturates; first tick times out at once
      put_item(CMD_START, 8'h00, 8'h10, 9'h1FF);
      put_item(CMD_TICK, 8'hFF, 8'h00, 9'h000);
      // announced length below the minimum: still ends at byte five
      put_item(CMD_START, 8'hFF, 8'h05, 9'd2);
      send_reply('{8'hFF, 8'h05, 8'h00}, 16'h0000, -1);
      // exception reply
      put_item(CMD_START, 8'h00, 8'h04, 9'd8);
      send_reply('{8'hFF, 8'h84, 8'h02}, 16'h0000, -1);
      settle();

      // Random phases across register settings; the last runs without idling
      ph_addr[0]    = 8'h01;
      ph_timeout[0] = 16'hFFFF;
      ph_addr[1]    = 8'h00;
      ph_timeout[1] = 16'd1;
      ph_addr[2]    = 8'($urandom());
      ph_timeout[2] = 16'($urandom_range(2, 40));
      ph_addr[3]    = 8'($urandom());
      ph_timeout[3] = 16'($urandom_range(3, 64));
      for (int p = 0; p < 4; p++) begin
         write_reg(CSR_SLAVE_ADDRESS, {8'h00, ph_addr[p]});
         write_reg(CSR_TIMEOUT_TICKS, ph_timeout[p]);
         if (p == 3) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         end
         tick_pct  = $urandom_range(2, 8);
         phase_end = sent_items + PHASE_ITEMS;
         if (p == 0) begin
            send_frame(256);
         end
         while (sent_items < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               put_item(2'($urandom()), 8'($urandom()), 8'($urandom()), 9'($urandom()));
            end else begin
               send_frame(0);
            end
         end
         settle();
      end

      repeat (DRAIN) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== modbus_rtu_response_checker_top.f =====
design/mrc_pkg.sv
design/mrc_if.sv
design/mrc_front.sv
design/mrc_queue.sv
design/mrc_back.sv
design/modbus_rtu_response_checker_top.sv
design/mrc_checker.sv
dv/mrc_tb_pkg.sv
dv/mrc_verdict_monitor.sv
dv/modbus_rtu_response_checker_top_tb.sv
